/* rtl/core/btc_pkg.sv */
package btc_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_PIXELS = 4;
    localparam int ROW_W      = PIX_W * ROW_PIXELS;
    localparam int STORE_ROWS = 3;
    localparam int SUM_W      = 12;
    localparam int SQ_W       = 20;
    localparam int PROD_W     = 2 * SUM_W;
    localparam int D_W        = 23;
    localparam int ROOT_W     = 12;
    localparam int ROOT_STEPS = 12;
    localparam int STEP_W     = 4;
    localparam int DEV_W      = 7;
    localparam int MAP_W      = 8;

    localparam logic [1:0]        LAST_ROW   = 2'd3;
    localparam logic [1:0]        LAST_PIXEL = 2'd3;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(ROOT_STEPS - 1);
    localparam logic [D_W-1:0]    FIRST_BIT  = D_W'(1) << (D_W - 1);
    localparam logic [DEV_W-1:0]  DEV_MAX    = 7'd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQUARE,
        ST_DIFF,
        ST_ROOT,
        ST_FINISH
    } enc_state_t;

    typedef struct packed {
        logic           start;
        logic [D_W-1:0] operand;
    } root_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } root_stat_t;

endpackage

/* rtl/core/btc_root.sv */
module btc_root (
    input  logic                clk,
    input  logic                rst_n,
    input  btc_pkg::root_ctrl_t ctrl,
    output btc_pkg::root_stat_t stat
);
    import btc_pkg::*;

    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    root_reg, root_next;
    logic [D_W-1:0]    bit_reg, bit_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [D_W:0]      trial;

    // one bit of the restoring root per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (ctrl.start)
        begin
            rem_next  = ctrl.operand;
            root_next = '0;
            bit_next  = FIRST_BIT;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next  = rem_reg - trial[D_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.root = root_reg[ROOT_W-1:0];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("root start while busy");

endmodule

/* rtl/core/btc_block_encoder.sv */
// 4x4 block truncation encoder for 8-bit luminance.
// Request channel: pixel_valid/pixel_ready with pixel_a..pixel_d, one block
// row per request, top row first, column 0 in pixel_a.
// Code channel: code_valid/code_ready with block_mean, block_deviation,
// upper_map and lower_map, one code per four rows.
// For rows 0 to 2, one shared 12x12 multiplier squares one pixel per
// cycle into the running sums, then the row goes to the row store.
// Row 3 takes its pixels the same way, then squares the sum on the
// same multiplier, forms 16*Q - S*S and starts the root, waits through
// the root's 12 bit-serial steps and its done flag, and builds the maps;
// the code is registered as the maps are built and is available in the cycle after.
// The code sits in an output register; new rows are taken while it waits.
// If the receiver stalls with a code still held, the next block's last row
// waits in its finish step until the held code is taken.
// Reset clears the row position and sums; the next request is row 0.
module btc_block_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [btc_pkg::PIX_W-1:0]   pixel_a,
    input  logic [btc_pkg::PIX_W-1:0]   pixel_b,
    input  logic [btc_pkg::PIX_W-1:0]   pixel_c,
    input  logic [btc_pkg::PIX_W-1:0]   pixel_d,
    output logic                        code_valid,
    input  logic                        code_ready,
    output logic [btc_pkg::PIX_W-1:0]   block_mean,
    output logic [btc_pkg::DEV_W-1:0]   block_deviation,
    output logic [btc_pkg::MAP_W-1:0]   upper_map,
    output logic [btc_pkg::MAP_W-1:0]   lower_map
);
    import btc_pkg::*;

    enc_state_t         state_reg, state_next;
    logic [ROW_W-1:0]   row_store_reg [STORE_ROWS];
    logic [ROW_W-1:0]   row_in_reg, row_in_next;
    logic [1:0]         row_pos_reg, row_pos_next;
    logic [1:0]         pix_idx_reg, pix_idx_next;
    logic [SUM_W-1:0]   pixel_total_reg, pixel_total_next;
    logic [SQ_W-1:0]    square_total_reg, square_total_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               code_valid_reg, code_valid_next;
    logic [PIX_W-1:0]   mean_reg, mean_next;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic [MAP_W-1:0]   upper_reg, upper_next;
    logic [MAP_W-1:0]   lower_reg, lower_next;
    logic               store_row;

    logic [PIX_W-1:0]   cur_pix;
    logic [SUM_W-1:0]   mul_op;
    logic [PROD_W-1:0]  mul_prod;
    logic [PROD_W-1:0]  sq_scaled;
    logic [PROD_W-1:0]  diff;
    logic [ROW_W-1:0]   block_rows [ROW_PIXELS];
    logic [2*MAP_W-1:0] block_map;
    logic [PIX_W-1:0]   dev_full;

    root_ctrl_t         root_ctrl;
    root_stat_t         root_stat;

    btc_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (root_ctrl),
        .stat  (root_stat)
    );

    assign cur_pix   = (state_reg == ST_IDLE) ? pixel_a : row_in_reg[PIX_W*pix_idx_reg +: PIX_W];
    assign mul_op    = (state_reg == ST_SQUARE) ? pixel_total_reg : {4'b0, cur_pix};
    assign mul_prod  = mul_op * mul_op;
    assign sq_scaled = {square_total_reg, 4'b0};
    assign diff      = (sq_scaled >= prod_reg) ? (sq_scaled - prod_reg) : '0;
    assign dev_full  = root_stat.root[ROOT_W-1:4];

    always_comb
    begin
        for (int r = 0; r < STORE_ROWS; r++)
        begin
            block_rows[r] = row_store_reg[r];
        end
        block_rows[ROW_PIXELS-1] = row_in_reg;
        for (int r = 0; r < ROW_PIXELS; r++)
        begin
            for (int i = 0; i < ROW_PIXELS; i++)
            begin
                block_map[2*MAP_W-1-ROW_PIXELS*r-i] =
                    ({block_rows[r][PIX_W*i +: PIX_W], 4'b0} >= pixel_total_reg);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        row_in_next       = row_in_reg;
        row_pos_next      = row_pos_reg;
        pix_idx_next      = pix_idx_reg;
        pixel_total_next  = pixel_total_reg;
        square_total_next = square_total_reg;
        prod_next         = prod_reg;
        code_valid_next   = code_valid_reg && !code_ready;
        mean_next         = mean_reg;
        dev_next          = dev_reg;
        upper_next        = upper_reg;
        lower_next        = lower_reg;
        store_row         = 1'b0;
        pixel_ready       = 1'b0;
        root_ctrl.start   = 1'b0;
        root_ctrl.operand = diff[D_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    row_in_next       = {pixel_d, pixel_c, pixel_b, pixel_a};
                    pixel_total_next  = pixel_total_reg + {4'b0, cur_pix};
                    square_total_next = square_total_reg + mul_prod[SQ_W-1:0];
                    pix_idx_next      = 2'd1;
                    state_next        = ST_ACC;
                end
            end
            ST_ACC:
            begin
                pixel_total_next  = pixel_total_reg + {4'b0, cur_pix};
                square_total_next = square_total_reg + mul_prod[SQ_W-1:0];
                pix_idx_next      = pix_idx_reg + 1'b1;
                if (pix_idx_reg == LAST_PIXEL)
                begin
                    if (row_pos_reg == LAST_ROW)
                    begin
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        store_row    = 1'b1;
                        row_pos_next = row_pos_reg + 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SQUARE:
            begin
                prod_next  = mul_prod;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                root_ctrl.start = 1'b1;
                state_next      = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!code_valid_reg || code_ready)
                begin
                    code_valid_next   = 1'b1;
                    mean_next         = pixel_total_reg[SUM_W-1:4];
                    dev_next          = (dev_full > {1'b0, DEV_MAX}) ? DEV_MAX
                                                                     : dev_full[DEV_W-1:0];
                    upper_next        = block_map[2*MAP_W-1:MAP_W];
                    lower_next        = block_map[MAP_W-1:0];
                    pixel_total_next  = '0;
                    square_total_next = '0;
                    row_pos_next      = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < STORE_ROWS; r++)
            begin
                row_store_reg[r] <= '0;
            end
            row_in_reg       <= '0;
            row_pos_reg      <= '0;
            pix_idx_reg      <= '0;
            pixel_total_reg  <= '0;
            square_total_reg <= '0;
            prod_reg         <= '0;
            code_valid_reg   <= 1'b0;
            mean_reg         <= '0;
            dev_reg          <= '0;
            upper_reg        <= '0;
            lower_reg        <= '0;
        end
        else
        begin
            if (store_row)
            begin
                row_store_reg[row_pos_reg] <= row_in_reg;
            end
            row_in_reg       <= row_in_next;
            row_pos_reg      <= row_pos_next;
            pix_idx_reg      <= pix_idx_next;
            pixel_total_reg  <= pixel_total_next;
            square_total_reg <= square_total_next;
            prod_reg         <= prod_next;
            code_valid_reg   <= code_valid_next;
            mean_reg         <= mean_next;
            dev_reg          <= dev_next;
            upper_reg        <= upper_next;
            lower_reg        <= lower_next;
        end
    end

    assign code_valid      = code_valid_reg;
    assign block_mean      = mean_reg;
    assign block_deviation = dev_reg;
    assign upper_map       = upper_reg;
    assign lower_map       = lower_reg;

    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready) |=> (state_reg == ST_ACC))
        else $error("request accepted without accumulation");

    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_stat.done |-> (state_reg == ST_ROOT))
        else $error("root done outside root wait");

    a_root_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_stat.busy |-> (state_reg == ST_ROOT))
        else $error("root busy outside root wait");

    a_code_clears_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE)
            |=> (code_valid_reg && row_pos_reg == 2'd0 && pixel_total_reg == '0))
        else $error("block end left state behind");

endmodule
